>>> src/imj_pkg.sv
`default_nettype none

package imj_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [15:0] SPREAD_MOD = 16'd10000;
  localparam logic [15:0] RESET_INTERVAL = 16'd30000;
  localparam logic [15:0] RESET_STEP_DELAY = 16'd20;
  localparam logic [31:0] RESET_AUTO_OFF = 32'd28800000;
  localparam logic [15:0] RESET_BASE_INTERVAL = 16'd25000;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_TOGGLE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_WAKE    = 3'd3,
    CMD_SET_EN  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IS_MASTER     = 2'd0,
    CFG_STEP_DELAY    = 2'd1,
    CFG_AUTO_OFF      = 2'd2,
    CFG_BASE_INTERVAL = 2'd3
  } cfg_idx_t;

  typedef logic [TIME_BITS-1:0] time_t;

  // The 16-bit timer is below seven times the modulus, so one set of parallel
  // compares picks the multiple to take away and a single subtract follows.
  function automatic logic [15:0] spread_of(input logic [15:0] v);
    logic [15:0] sub;
    begin
      if (v >= 16'(6 * SPREAD_MOD)) begin
        sub = 16'(6 * SPREAD_MOD);
      end else if (v >= 16'(5 * SPREAD_MOD)) begin
        sub = 16'(5 * SPREAD_MOD);
      end else if (v >= 16'(4 * SPREAD_MOD)) begin
        sub = 16'(4 * SPREAD_MOD);
      end else if (v >= 16'(3 * SPREAD_MOD)) begin
        sub = 16'(3 * SPREAD_MOD);
      end else if (v >= 16'(2 * SPREAD_MOD)) begin
        sub = 16'(2 * SPREAD_MOD);
      end else if (v >= SPREAD_MOD) begin
        sub = SPREAD_MOD;
      end else begin
        sub = 16'd0;
      end
      spread_of = v - sub;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/idle_mouse_jiggler_unit.sv
// An accepted input beat passes the input register, then the event logic into
// the result register; it waits in the input register while a result is stalled.
// Throughput: one beat per cycle while out_stall is low; the state update is a
// single pass of compares and a constant modulo on the timer's low 16 bits.
// Reset (rst_n low, synchronous) empties both stages and restores all state and
// configuration to their defaults.
`default_nettype none

module idle_mouse_jiggler_unit import imj_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [2:0]               in_command,
  input  wire  [31:0]              in_idle_ms,
  input  wire                      in_enable_value,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic                     out_move_valid,
  output logic signed [1:0]        out_move_dx,
  output logic signed [1:0]        out_move_dy,
  output logic                     out_enabled,
  input  wire                      cfg_wr_en,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_wdata
);

  // Configuration.
  logic        is_master_r;
  logic [15:0] step_delay_r;
  logic [31:0] auto_off_r;
  logic [15:0] base_interval_r;

  // Input stage.
  logic        in_vld_r;
  logic [2:0]  cmd_r;
  logic [31:0] idle_r;
  logic        en_val_r;

  // Jiggler state.
  time_t       now_r, now_nxt;
  logic        jiggle_on_r, jiggle_on_nxt;
  logic        ret_pend_r, ret_pend_nxt;
  logic        axis_x_r, axis_x_nxt;
  time_t       wait_start_r, wait_start_nxt;
  time_t       step_start_r, step_start_nxt;
  time_t       run_start_r, run_start_nxt;
  logic [15:0] wait_intv_r, wait_intv_nxt;
  logic        asleep_r, asleep_nxt;

  // Result stage.
  logic              out_vld_r;
  logic              mv_r, mv_nxt;
  logic signed [1:0] dx_r, dx_nxt;
  logic signed [1:0] dy_r, dy_nxt;
  logic              en_out_r;

  logic  out_free;
  logic  proc;
  logic  in_acc;
  time_t now_inc;
  time_t since_run, since_wait, since_step;

  assign out_free = !out_vld_r || !out_stall;
  assign proc     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign now_inc    = now_r + time_t'(1);
  assign since_run  = now_inc - run_start_r;
  assign since_wait = now_inc - wait_start_r;
  assign since_step = now_inc - step_start_r;

  always_comb begin
    now_nxt        = now_r;
    jiggle_on_nxt  = jiggle_on_r;
    ret_pend_nxt   = ret_pend_r;
    axis_x_nxt     = axis_x_r;
    wait_start_nxt = wait_start_r;
    step_start_nxt = step_start_r;
    run_start_nxt  = run_start_r;
    wait_intv_nxt  = wait_intv_r;
    asleep_nxt     = asleep_r;
    mv_nxt         = 1'b0;
    dx_nxt         = 2'sd0;
    dy_nxt         = 2'sd0;
    case (cmd_r)
      CMD_TICK: begin
        now_nxt = now_inc;
        if (jiggle_on_r && is_master_r && !asleep_r) begin
          if (32'(since_run) >= auto_off_r) begin
            jiggle_on_nxt = 1'b0;
            ret_pend_nxt  = 1'b0;
          end else if (idle_r < 32'(wait_intv_r)) begin
            wait_start_nxt = now_inc;
          end else if (!ret_pend_r) begin
            if (since_wait >= time_t'(wait_intv_r)) begin
              axis_x_nxt     = !axis_x_r;
              mv_nxt         = 1'b1;
              dx_nxt         = !axis_x_r ? 2'sd1 : 2'sd0;
              dy_nxt         = !axis_x_r ? 2'sd0 : 2'sd1;
              ret_pend_nxt   = 1'b1;
              step_start_nxt = now_inc;
            end
          end else if (since_step >= time_t'(step_delay_r)) begin
            mv_nxt         = 1'b1;
            dx_nxt         = axis_x_r ? -2'sd1 : 2'sd0;
            dy_nxt         = axis_x_r ? 2'sd0 : -2'sd1;
            ret_pend_nxt   = 1'b0;
            wait_start_nxt = now_inc;
            wait_intv_nxt  = base_interval_r + spread_of(now_inc[15:0]);
          end
        end
      end
      CMD_TOGGLE: begin
        jiggle_on_nxt  = !jiggle_on_r;
        ret_pend_nxt   = 1'b0;
        wait_start_nxt = now_r;
        run_start_nxt  = now_r;
        wait_intv_nxt  = base_interval_r + spread_of(now_r[15:0]);
      end
      CMD_SUSPEND: asleep_nxt = 1'b1;
      CMD_WAKE: begin
        asleep_nxt     = 1'b0;
        wait_start_nxt = now_r;
      end
      CMD_SET_EN: jiggle_on_nxt = en_val_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_master_r     <= 1'b1;
      step_delay_r    <= RESET_STEP_DELAY;
      auto_off_r      <= RESET_AUTO_OFF;
      base_interval_r <= RESET_BASE_INTERVAL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IS_MASTER:     is_master_r     <= cfg_wdata[0];
        CFG_STEP_DELAY:    step_delay_r    <= cfg_wdata[15:0];
        CFG_AUTO_OFF:      auto_off_r      <= cfg_wdata[31:0];
        CFG_BASE_INTERVAL: base_interval_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_command;
      idle_r   <= in_idle_ms;
      en_val_r <= in_enable_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      jiggle_on_r  <= 1'b0;
      ret_pend_r   <= 1'b0;
      axis_x_r     <= 1'b0;
      wait_start_r <= '0;
      step_start_r <= '0;
      run_start_r  <= '0;
      wait_intv_r  <= RESET_INTERVAL;
      asleep_r     <= 1'b0;
    end else if (proc) begin
      now_r        <= now_nxt;
      jiggle_on_r  <= jiggle_on_nxt;
      ret_pend_r   <= ret_pend_nxt;
      axis_x_r     <= axis_x_nxt;
      wait_start_r <= wait_start_nxt;
      step_start_r <= step_start_nxt;
      run_start_r  <= run_start_nxt;
      wait_intv_r  <= wait_intv_nxt;
      asleep_r     <= asleep_nxt;
    end
  end

  // A result beat leaves the register when taken; a new one overwrites it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      mv_r     <= mv_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      en_out_r <= jiggle_on_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_move_valid = mv_r;
  assign out_move_dx    = dx_r;
  assign out_move_dy    = dy_r;
  assign out_enabled    = en_out_r;

endmodule

`default_nettype wire

>>> src/imj_checker.sv
`default_nettype none

module imj_checker import imj_pkg::*; (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire                      out_move_valid,
  input wire signed [1:0]         out_move_dx,
  input wire signed [1:0]         out_move_dy,
  input wire                      out_enabled
);

  // A reported move is a single step on exactly one axis; no move means zeros.
  a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_move_valid ?
      ((out_move_dx != 2'sd0) != (out_move_dy != 2'sd0)) &&
      (out_move_dx != -2'sd2) && (out_move_dy != -2'sd2) :
      (out_move_dx == 2'sd0) && (out_move_dy == 2'sd0)))
    else $error("malformed move report");

  // Moves are only sent while the jiggler stays enabled.
  a_move_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_valid |-> out_enabled)
    else $error("move reported while disabled");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_move_valid) &&
      $stable(out_move_dx) && $stable(out_move_dy) && $stable(out_enabled))
    else $error("stalled result changed");

  // The input is only held off while a result beat is waiting to be taken.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  // Nothing comes out the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind idle_mouse_jiggler_unit imj_checker u_imj_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_move_valid (out_move_valid),
  .out_move_dx    (out_move_dx),
  .out_move_dy    (out_move_dy),
  .out_enabled    (out_enabled)
);

`default_nettype wire
